@@ rtl/core/necir_pkg.sv @@
`default_nettype none

package necir_pkg;

   localparam int unsigned TICK_W      = 16;
   localparam int unsigned BIT_CNT_W   = 6;
   localparam int unsigned WORD_W      = 16;
   localparam int unsigned BYTE_W      = 8;

   localparam logic [BIT_CNT_W-1:0] HALF_FRAME_BITS = 6'd16;
   localparam logic [BIT_CNT_W-1:0] FULL_FRAME_BITS = 6'd32;

   localparam logic [BYTE_W-1:0] OVERFLOW_MS   = 8'd125;
   localparam logic [BYTE_W-1:0] RELEASE_LIMIT = 8'd120;
   localparam logic [BYTE_W-1:0] CMD_LIMIT     = 8'd96;

   localparam logic [TICK_W-1:0] BIT_MAX_MS    = 16'd7;
   localparam logic [TICK_W-1:0] ONE_BIT_MS    = 16'd2;
   localparam logic [TICK_W-1:0] REPEAT_MIN_MS = 16'd10;
   localparam logic [TICK_W-1:0] REPEAT_MAX_MS = 16'd12;

   typedef struct packed {
      logic [BYTE_W-1:0] ms_low;
      logic              is_bit;
      logic              is_one;
      logic              is_repeat;
   } interval_class_type;

endpackage

`default_nettype wire

@@ rtl/core/necir_interval_classify.sv @@
`default_nettype none

module necir_interval_classify #(
   parameter int unsigned TICKS_PER_MS = 375
) (
   input  wire logic [necir_pkg::TICK_W-1:0] interval_ticks,
   input  wire logic                         is_overflow,
   output necir_pkg::interval_class_type     interval_class
);
   import necir_pkg::*;

   localparam int unsigned SHIFT_W = TICK_W + $clog2(TICKS_PER_MS);
   localparam int unsigned PROD_W  = SHIFT_W + TICK_W;
   localparam longint unsigned RECIP =
      ((64'd1 << SHIFT_W) + 64'(TICKS_PER_MS) - 64'd1) / 64'(TICKS_PER_MS);
   localparam logic [PROD_W-1:0] RECIP_V = PROD_W'(RECIP);

   logic [PROD_W-1:0] product;
   logic [TICK_W-1:0] ms;

   assign product = PROD_W'(interval_ticks) * RECIP_V;
   assign ms      = product[SHIFT_W +: TICK_W];

   always_comb begin
      if (is_overflow) begin
         interval_class.ms_low    = OVERFLOW_MS;
         interval_class.is_bit    = 1'b0;
         interval_class.is_one    = 1'b0;
         interval_class.is_repeat = 1'b0;
      end else begin
         interval_class.ms_low    = ms[BYTE_W-1:0];
         interval_class.is_bit    = (ms != '0) && (ms <= BIT_MAX_MS);
         interval_class.is_one    = (ms == ONE_BIT_MS);
         interval_class.is_repeat = (ms >= REPEAT_MIN_MS) && (ms <= REPEAT_MAX_MS);
      end
   end

endmodule

`default_nettype wire

@@ rtl/core/nec_ir_pulse_decoder_unit.sv @@
// Path: an accepted req word goes through the input register, then the result register.
// Throughput: one word per cycle while rsp_ready keeps up; the input register and the
// result register each hold one word, and a reciprocal multiply sets the per-cycle path.
// Reset: synchronous, active high; clears the decoder state, the stored
// no-key code and both valid flags.
`default_nettype none

module nec_ir_pulse_decoder_unit #(
   parameter int unsigned TICKS_PER_MS = 375
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output      logic                            req_ready,
   input  wire logic [necir_pkg::TICK_W-1:0]    req_interval_ticks,
   input  wire logic                            req_is_overflow,
   output      logic                            rsp_valid,
   input  wire logic                            rsp_ready,
   output      logic [necir_pkg::BIT_CNT_W-1:0] rsp_bit_count,
   output      logic [necir_pkg::WORD_W-1:0]    rsp_user_code,
   output      logic [necir_pkg::WORD_W-1:0]    rsp_data_word,
   output      logic                            rsp_key_held,
   output      logic                            rsp_frame_ready,
   input  wire logic                            csr_valid,
   output      logic                            csr_ready,
   input  wire logic [necir_pkg::BYTE_W-1:0]    csr_wdata
);
   import necir_pkg::*;

   logic                 in_valid_ff;
   logic [TICK_W-1:0]    in_ticks_ff;
   logic                 in_ovf_ff;
   logic                 out_valid_ff;
   logic [BYTE_W-1:0]    no_key_ff;

   logic [BIT_CNT_W-1:0] bit_cnt_ff, bit_cnt_in;
   logic [WORD_W-1:0]    shift_ff, shift_in;
   logic [WORD_W-1:0]    addr_ff, addr_in;
   logic [BYTE_W-1:0]    accum_ff, accum_in;
   logic                 held_ff, held_in;

   interval_class_type   iclass;
   logic                 advance;
   logic [BYTE_W-1:0]    accum_sum;
   logic [WORD_W-1:0]    shifted;
   logic [BIT_CNT_W-1:0] bit_next;

   necir_interval_classify #(
      .TICKS_PER_MS(TICKS_PER_MS)
   ) u_classify (
      .interval_ticks(in_ticks_ff),
      .is_overflow(in_ovf_ff),
      .interval_class(iclass)
   );

   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign csr_ready = 1'b1;

   assign accum_sum = accum_ff + iclass.ms_low;
   assign shifted   = {iclass.is_one, shift_ff[WORD_W-1:1]};
   assign bit_next  = bit_cnt_ff + 6'd1;

   always_comb begin
      bit_cnt_in = bit_cnt_ff;
      shift_in   = shift_ff;
      addr_in    = addr_ff;
      accum_in   = accum_ff;
      held_in    = held_ff || !in_ovf_ff;
      if (bit_cnt_ff == FULL_FRAME_BITS) begin
         if (iclass.is_repeat) begin
            accum_in = '0;
         end else begin
            accum_in = accum_sum;
            if (accum_sum > RELEASE_LIMIT) begin
               bit_cnt_in = '0;
               held_in    = 1'b0;
            end
         end
      end else if (!iclass.is_bit) begin
         accum_in   = '0;
         bit_cnt_in = '0;
         held_in    = 1'b0;
      end else begin
         bit_cnt_in = bit_next;
         shift_in   = shifted;
         if (bit_next == HALF_FRAME_BITS) begin
            addr_in = shifted;
         end else if ((bit_next == FULL_FRAME_BITS) && (shifted[BYTE_W-1:0] >= CMD_LIMIT)) begin
            shift_in = {{(WORD_W-BYTE_W){1'b0}}, no_key_ff};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         no_key_ff    <= '0;
         bit_cnt_ff   <= '0;
         shift_ff     <= '0;
         addr_ff      <= '0;
         accum_ff     <= '0;
         held_ff      <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
         if (csr_valid && csr_ready) begin
            no_key_ff <= csr_wdata;
         end
         if (advance) begin
            bit_cnt_ff <= bit_cnt_in;
            shift_ff   <= shift_in;
            addr_ff    <= addr_in;
            accum_ff   <= accum_in;
            held_ff    <= held_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_ticks_ff <= req_interval_ticks;
         in_ovf_ff   <= req_is_overflow;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_bit_count   = bit_cnt_ff;
   assign rsp_user_code   = addr_ff;
   assign rsp_data_word   = shift_ff;
   assign rsp_key_held    = held_ff;
   assign rsp_frame_ready = (bit_cnt_ff == FULL_FRAME_BITS);

endmodule

`default_nettype wire

@@ rtl/core/necir_checker.sv @@
`default_nettype none

module necir_checker (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            req_valid,
   input wire logic                            req_ready,
   input wire logic                            rsp_valid,
   input wire logic                            rsp_ready,
   input wire logic [necir_pkg::BIT_CNT_W-1:0] rsp_bit_count,
   input wire logic [necir_pkg::WORD_W-1:0]    rsp_user_code,
   input wire logic [necir_pkg::WORD_W-1:0]    rsp_data_word,
   input wire logic                            rsp_key_held,
   input wire logic                            rsp_frame_ready
);
   import necir_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_bit_count)
         && $stable(rsp_user_code) && $stable(rsp_data_word)
         && $stable(rsp_key_held) && $stable(rsp_frame_ready))
      else $error("rsp word changed while stalled");

   a_frame_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_frame_ready == (rsp_bit_count == FULL_FRAME_BITS))
      else $error("frame_ready disagrees with bit_count");

   a_bit_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_bit_count <= FULL_FRAME_BITS)
      else $error("bit_count above a full frame");

   a_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid && (rsp_bit_count == '0) && !rsp_key_held
         && (rsp_user_code == '0) && (rsp_data_word == '0))
      else $error("decoder state not cleared by reset");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |-> rsp_valid && !rsp_ready)
      else $error("req stalled with rsp side free");

endmodule

bind nec_ir_pulse_decoder_unit necir_checker u_necir_checker (.*);

`default_nettype wire
